@@ rtl/core/sacf_pkg.sv @@
`default_nettype none

package sacf_pkg;

    // defaults for the top-level parameters
    localparam int DEF_SETS      = 64;
    localparam int DEF_WAYS      = 4;
    localparam int DEF_ADDR_BITS = 32;

    // fixed port widths
    localparam int ADDR_PORT_W = 32;
    localparam int WAY_USED_W  = 2;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIVIDE,
        ST_LOOKUP
    } ctl_state_t;

    // controller to datapath
    typedef struct packed {
        logic clear_wr;
        logic load;
        logic div_step;
        logic lookup;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic div_done;
    } ctl_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/sacf_ram.sv @@
`default_nettype none

module sacf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/core/sacf_ctrl.sv @@
`default_nettype none

module sacf_ctrl
    import sacf_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire ctl_sts_t sts,
    output ctl_cmd_t      cmd,
    output logic          busy
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (sts.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                // set index final: the row read this cycle is the right one
                if (sts.div_done)
                begin
                    state_next = ST_LOOKUP;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

@@ rtl/core/sacf_dpath.sv @@
`default_nettype none

module sacf_dpath
    import sacf_pkg::*;
#(
    parameter int SETS      = DEF_SETS,
    parameter int WAYS      = DEF_WAYS,
    parameter int ADDR_BITS = DEF_ADDR_BITS
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [ADDR_PORT_W-1:0] address,
    input  wire ctl_cmd_t               cmd,
    output ctl_sts_t                    sts,
    output logic                        done,
    output logic                        hit,
    output logic      [WAY_USED_W-1:0]  way_used,
    output logic                        evicted_valid,
    output logic      [ADDR_PORT_W-1:0] evicted_address
);

    localparam int AW       = (ADDR_BITS < ADDR_PORT_W) ? ADDR_BITS : ADDR_PORT_W;
    localparam int IDX_W    = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int SETS_L   = $clog2(SETS);
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CNT_W    = $clog2(WAYS + 1);
    localparam int ROW_W    = WAYS * AW + CNT_W + WAY_W;
    localparam int RECIP_W  = AW + 2;
    localparam int PROD_W   = AW + RECIP_W;
    localparam int QSH      = AW + SETS_L;
    localparam bit SETS_POW2 = (SETS == (1 << $clog2(SETS)));
    // rounded-up reciprocal: floor(a * RECIP / 2^QSH) is a / SETS for every a
    localparam logic [63:0]        RECIP_FULL = ((64'd1 << QSH) / 64'(SETS)) + 64'd1;
    localparam logic [RECIP_W-1:0] RECIP      = RECIP_FULL[RECIP_W-1:0];
    localparam logic [AW-1:0]    SETS_A   = AW'(SETS);
    localparam logic [AW-1:0]    SET_MASK = AW'(SETS - 1);
    localparam logic [1:0]       DIV_STEPS = 2'd2;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(WAYS);
    localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(WAYS - 1);

    // row layout: {fill pointer, fill count, way addresses}
    // ways fill in order and are never dropped, so way w is valid iff w < count

    logic [AW-1:0]     addr_reg;
    logic [AW-1:0]     quo_reg;
    logic [IDX_W-1:0]  set_reg;
    logic [1:0]        div_cnt_reg;
    logic [IDX_W-1:0]  clr_cnt_reg;
    logic              done_reg;
    logic              hit_reg;
    logic [WAY_USED_W-1:0]  way_reg;
    logic              ev_valid_reg;
    logic [ADDR_PORT_W-1:0] ev_addr_reg;

    logic [PROD_W-1:0] prod;
    logic [AW-1:0]     quo_next;
    logic [AW-1:0]     rem_full;
    logic [IDX_W-1:0]  set_idx;

    logic [ROW_W-1:0]  rdata;
    logic [ROW_W-1:0]  row_next;
    logic [ROW_W-1:0]  wdata;
    logic [IDX_W-1:0]  waddr;
    logic              we;

    logic [AW-1:0]     way_addr [WAYS];
    logic [CNT_W-1:0]  fill_cnt;
    logic [WAY_W-1:0]  fill_ptr;
    logic              hit_c;
    logic [WAY_W-1:0]  hit_way;
    logic              full_c;
    logic [WAY_W-1:0]  fill_way;
    logic [AW-1:0]     victim_addr;

    // set index when SETS is not a power of two: quotient by reciprocal
    // multiply, then address minus quotient times SETS
    assign prod     = PROD_W'(addr_reg) * PROD_W'(RECIP);
    assign quo_next = AW'(prod >> QSH);
    assign rem_full = addr_reg - (quo_reg * SETS_A);
    assign set_idx  = set_reg;

    assign sts.div_done   = (div_cnt_reg == '0);
    assign sts.clear_done = (clr_cnt_reg == IDX_W'(SETS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.lookup;
            if (cmd.clear_wr)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.load)
            begin
                div_cnt_reg <= SETS_POW2 ? 2'd0 : DIV_STEPS;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            addr_reg <= address[AW-1:0];
            set_reg  <= SETS_POW2 ? IDX_W'(address[AW-1:0] & SET_MASK) : '0;
        end
        else if (cmd.div_step)
        begin
            if (div_cnt_reg == DIV_STEPS)
            begin
                quo_reg <= quo_next;
            end
            else
            begin
                set_reg <= IDX_W'(rem_full);
            end
        end
        if (cmd.lookup)
        begin
            hit_reg      <= hit_c;
            way_reg      <= hit_c ? WAY_USED_W'(hit_way) : WAY_USED_W'(fill_way);
            ev_valid_reg <= !hit_c && full_c;
            ev_addr_reg  <= (!hit_c && full_c) ? ADDR_PORT_W'(victim_addr) : '0;
        end
    end

    // tag compare and fifo choice on the row just read
    always_comb
    begin
        hit_c   = 1'b0;
        hit_way = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            way_addr[w] = rdata[w*AW +: AW];
        end
        fill_cnt = rdata[WAYS*AW +: CNT_W];
        fill_ptr = rdata[WAYS*AW + CNT_W +: WAY_W];
        // highest first so the lowest matching way wins
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if ((CNT_W'(w) < fill_cnt) && (way_addr[w] == addr_reg))
            begin
                hit_c   = 1'b1;
                hit_way = WAY_W'(w);
            end
        end
        full_c      = (fill_cnt == FULL_CNT);
        fill_way    = full_c ? fill_ptr : WAY_W'(fill_cnt);
        victim_addr = way_addr[fill_way];

        row_next = rdata;
        for (int w = 0; w < WAYS; w++)
        begin
            if (WAY_W'(w) == fill_way)
            begin
                row_next[w*AW +: AW] = addr_reg;
            end
        end
        if (full_c)
        begin
            row_next[WAYS*AW + CNT_W +: WAY_W] = (fill_ptr == LAST_WAY) ? '0
                                                 : fill_ptr + 1'b1;
        end
        else
        begin
            row_next[WAYS*AW +: CNT_W] = fill_cnt + 1'b1;
        end
    end

    assign we    = cmd.clear_wr || (cmd.lookup && !hit_c);
    assign waddr = cmd.clear_wr ? clr_cnt_reg : set_idx;
    assign wdata = cmd.clear_wr ? '0 : row_next;

    sacf_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_row_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (set_idx),
        .rdata (rdata)
    );

    assign done            = done_reg;
    assign hit             = hit_reg;
    assign way_used        = way_reg;
    assign evicted_valid   = ev_valid_reg;
    assign evicted_address = ev_addr_reg;

endmodule

`default_nettype wire

@@ rtl/core/set_assoc_cache_fifo_top.sv @@
`default_nettype none

// set-associative tag array with fifo replacement
//
// input: pulse start with a block address while busy is low; the beat is
//   taken at that edge. set index is address mod SETS, tag the full address
// output: one result beat per access, shown for exactly one cycle with done
//   high: hit, way_used (way that hit or way filled), and on a miss into a
//   full set evicted_valid with the replaced block address
// the receiver cannot stall; done is a single-cycle strobe and must be taken
// steps: the accepting edge loads the address and, when SETS is a power of
//   two, the set index; otherwise the set index follows from a reciprocal
//   multiply for the quotient, then the remainder; the row is then read,
//   compared in the lookup state and the result registered with done
// accesses: one at a time, busy covers the whole access, so the next beat
//   is taken in the cycle done is high
// each set lives in one row of a single ram: all way addresses, a fill
//   count and the fifo pointer
// reset: a clearing pass writes every row to zero with busy high,
//   before the first access is taken
module set_assoc_cache_fifo_top
    import sacf_pkg::*;
#(
    parameter int SETS      = DEF_SETS,
    parameter int WAYS      = DEF_WAYS,
    parameter int ADDR_BITS = DEF_ADDR_BITS
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [ADDR_PORT_W-1:0] address,
    output logic                        busy,
    output logic                        done,
    output logic                        hit,
    output logic      [WAY_USED_W-1:0]  way_used,
    output logic                        evicted_valid,
    output logic      [ADDR_PORT_W-1:0] evicted_address
);

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    // sequencer: clear pass, accept, divide, lookup
    sacf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // set index unit, row ram, compare and fill logic, result registers
    sacf_dpath #(
        .SETS      (SETS),
        .WAYS      (WAYS),
        .ADDR_BITS (ADDR_BITS)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .address         (address),
        .cmd             (cmd),
        .sts             (sts),
        .done            (done),
        .hit             (hit),
        .way_used        (way_used),
        .evicted_valid   (evicted_valid),
        .evicted_address (evicted_address)
    );

endmodule

`default_nettype wire
